// ===== src/tspp_pkg.sv =====
// Shared types and constants of the transport stream packet parser.
package tspp_pkg;

   localparam logic [7:0] SYNC_VALUE   = 8'h47;
   localparam logic [7:0] HEADER_BYTES = 8'd4;

   localparam logic [1:0] MODE_188 = 2'd0;
   localparam logic [1:0] MODE_192 = 2'd1;
   localparam logic [1:0] MODE_204 = 2'd2;

   localparam logic [7:0] LAST_POS_188 = 8'd187;
   localparam logic [7:0] LAST_POS_192 = 8'd191;
   localparam logic [7:0] LAST_POS_204 = 8'd203;

   localparam logic [1:0] CLASS_HEADER  = 2'd0;
   localparam logic [1:0] CLASS_ADAPT   = 2'd1;
   localparam logic [1:0] CLASS_PAYLOAD = 2'd2;
   localparam logic [1:0] CLASS_DISCARD = 2'd3;

   localparam logic [1:0] AFC_RESERVED     = 2'd0;
   localparam logic [1:0] AFC_PAYLOAD_ONLY = 2'd1;
   localparam logic [1:0] AFC_ADAPT_ONLY   = 2'd2;
   localparam logic [1:0] AFC_BOTH         = 2'd3;

   localparam logic [2:0] REG_PACKET_SIZE_MODE = 3'd0;

   typedef struct packed {
      logic [3:0]  continuity;
      logic [1:0]  adaptation_control;
      logic [1:0]  scrambling;
      logic        priority_res;
      logic        unit_start;
      logic        transport_error;
      logic [12:0] pid;
      logic        length_error;
      logic        sync_error;
      logic [7:0]  out_byte;
      logic        last_of_packet;
      logic [1:0]  byte_class;
   } result_type;

endpackage

// ===== src/tspp_core.sv =====
// Packet position tracking, header capture and byte classification.
module tspp_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic [1:0]           size_mode,
   output tspp_pkg::result_type result
);

   logic [7:0]  pos_ff, pos_in;
   logic [2:0]  flags_ff, flags_in;
   logic [12:0] pid_ff, pid_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic [8:0]  alen_ff, alen_in;
   logic        sync_bad_ff, sync_bad_in;

   logic [7:0] last_pos;
   logic [8:0] room;
   logic [7:0] rel;
   logic [1:0] afc;
   logic [1:0] cls;
   logic       last;

   always_comb begin
      unique case (size_mode)
         tspp_pkg::MODE_192: last_pos = tspp_pkg::LAST_POS_192;
         tspp_pkg::MODE_204: last_pos = tspp_pkg::LAST_POS_204;
         default:            last_pos = tspp_pkg::LAST_POS_188;
      endcase
   end

   always_comb begin
      flags_in    = flags_ff;
      pid_in      = pid_ff;
      ctrl_in     = ctrl_ff;
      alen_in     = alen_ff;
      sync_bad_in = sync_bad_ff;
      afc         = ctrl_ff[5:4];
      rel         = pos_ff - tspp_pkg::HEADER_BYTES;
      cls         = tspp_pkg::CLASS_DISCARD;
      priority if (pos_ff == 8'd0) begin
         flags_in    = 3'd0;
         pid_in      = 13'd0;
         ctrl_in     = 8'd0;
         alen_in     = 9'd0;
         sync_bad_in = (data_byte != tspp_pkg::SYNC_VALUE);
         cls         = tspp_pkg::CLASS_HEADER;
      end else if (pos_ff == 8'd1) begin
         flags_in = data_byte[7:5];
         pid_in   = {data_byte[4:0], 8'd0};
         cls      = tspp_pkg::CLASS_HEADER;
      end else if (pos_ff == 8'd2) begin
         pid_in = {pid_ff[12:8], data_byte};
         cls    = tspp_pkg::CLASS_HEADER;
      end else if (pos_ff == 8'd3) begin
         ctrl_in = data_byte;
         cls     = tspp_pkg::CLASS_HEADER;
      end else begin
         unique case (afc)
            tspp_pkg::AFC_PAYLOAD_ONLY: cls = tspp_pkg::CLASS_PAYLOAD;
            tspp_pkg::AFC_ADAPT_ONLY, tspp_pkg::AFC_BOTH: begin
               priority if (pos_ff == tspp_pkg::HEADER_BYTES) begin
                  alen_in = {1'b0, data_byte} + 9'd1;
                  cls     = tspp_pkg::CLASS_ADAPT;
               end else if ({1'b0, rel} < alen_ff) begin
                  cls = tspp_pkg::CLASS_ADAPT;
               end else if (afc == tspp_pkg::AFC_BOTH) begin
                  cls = tspp_pkg::CLASS_PAYLOAD;
               end else begin
                  cls = tspp_pkg::CLASS_DISCARD;
               end
            end
            default: cls = tspp_pkg::CLASS_DISCARD;
         endcase
      end
      last   = (pos_ff >= last_pos);
      pos_in = last ? 8'd0 : pos_ff + 8'd1;
   end

   // bytes left after the header: last_pos + 1 - 4
   assign room = {1'b0, last_pos} - 9'd3;

   always_comb begin
      result.byte_class         = cls;
      result.last_of_packet     = last;
      result.out_byte           = data_byte;
      result.sync_error         = sync_bad_in;
      result.length_error       = (alen_in > room);
      result.pid                = pid_in;
      result.transport_error    = flags_in[2];
      result.unit_start         = flags_in[1];
      result.priority_res       = flags_in[0];
      result.scrambling         = ctrl_in[7:6];
      result.adaptation_control = ctrl_in[5:4];
      result.continuity         = ctrl_in[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 8'd0;
         flags_ff    <= 3'd0;
         pid_ff      <= 13'd0;
         ctrl_ff     <= 8'd0;
         alen_ff     <= 9'd0;
         sync_bad_ff <= 1'b0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         flags_ff    <= flags_in;
         pid_ff      <= pid_in;
         ctrl_ff     <= ctrl_in;
         alen_ff     <= alen_in;
         sync_bad_ff <= sync_bad_in;
      end
   end

endmodule

// ===== src/transport_stream_packet_parser.sv =====
// Top level of the transport stream packet parser: stream ports, register port, result beat.
// The result of each accepted byte is registered in res_ff and shown on the result channel from there.
// Throughput: one byte per cycle; the parse of each byte is one pass of tspp_core's logic.
// The input stalls only while a result beat is held and rsp_tready is low.
// Synchronous reset clears the packet position, captured header, size mode and result valid.
module transport_stream_packet_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_byte, [8] sync_error, [9] length_error,
                                    // [22:10] pid, [23] transport_error, [24] unit_start,
                                    // [25] priority_res, [27:26] scrambling,
                                    // [29:28] adaptation_control, [33:30] continuity, zero
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser,   // [1:0] byte_class
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                 req_accept;
   logic                 csr_write;
   logic [1:0]           mode_ff;
   logic                 valid_ff, valid_in;
   tspp_pkg::result_type res;
   tspp_pkg::result_type res_ff;

   assign req_tready = !valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign valid_in   = req_accept || (valid_ff && !rsp_tready);

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       ({csr_paddr[2], 2'b00} == tspp_pkg::REG_PACKET_SIZE_MODE);
   assign csr_prdata = ({csr_paddr[2], 2'b00} == tspp_pkg::REG_PACKET_SIZE_MODE) ?
                       {30'd0, mode_ff} : 32'd0;

   tspp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_tdata),
      .size_mode (mode_ff),
      .result    (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= tspp_pkg::MODE_188;
         valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            mode_ff <= csr_pwdata[1:0];
         end
         valid_ff <= valid_in;
      end
   end

   // hold the result beat until it is taken
   always_ff @(posedge clock) begin
      if (req_accept) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = res_ff.last_of_packet;
   assign rsp_tuser  = res_ff.byte_class;
   assign rsp_tdata  = {6'd0, res_ff.continuity, res_ff.adaptation_control,
                        res_ff.scrambling, res_ff.priority_res, res_ff.unit_start,
                        res_ff.transport_error, res_ff.pid, res_ff.length_error,
                        res_ff.sync_error, res_ff.out_byte};

   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("accepted byte produced no result beat");

   a_adapt_needs_afc: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == tspp_pkg::CLASS_ADAPT) |-> res_ff.adaptation_control[1])
      else $error("adaptation byte without adaptation field flag");

   a_payload_needs_afc: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == tspp_pkg::CLASS_PAYLOAD) |-> res_ff.adaptation_control[0])
      else $error("payload byte without payload flag");

   a_sync_header: assert property (@(posedge clock) disable iff (reset)
      (req_accept && res.byte_class == tspp_pkg::CLASS_HEADER &&
       res.pid == 13'd0 && res.adaptation_control == tspp_pkg::AFC_RESERVED &&
       res.transport_error == 1'b0 && res.length_error) |-> 1'b0)
      else $error("length error raised before adaptation field length byte");

endmodule
